>>> design/blm_pkg.sv
// ----------------------------------------------------------------------------
// blm_pkg
// Shared widths, register indexes, reset values and stage types for the
// battery level monitor.
// ----------------------------------------------------------------------------
package blm_pkg;

    // field widths
    localparam int SAMPLE_W = 12;
    localparam int MV_W     = 13;
    localparam int LEVEL_W  = 9;
    localparam int HYST_W   = 8;
    localparam int SUM_W    = 19;
    localparam int CFG_AW   = 3;

    // window reciprocal: floor(x / n) == (x * ceil(2^25 / n)) >> 25 for x < 2^19, n <= 64
    localparam int RECIP_SH = 25;
    localparam int RECIP_W  = RECIP_SH + 1;

    // level divide by ten: floor(x / 10) == (x * 52429) >> 19 for x < 2^18
    localparam int LVL_RECIP_W = 16;
    localparam logic [LVL_RECIP_W-1:0] LVL_RECIP = 16'd52429;
    localparam int LVL_SH = 19;

    localparam logic [MV_W-1:0] OFFSET_MV = 13'd5;

    // configuration register indexes
    localparam logic [CFG_AW-1:0] CFG_MIN_LEVEL  = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_MAX_LEVEL  = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_LOW_PROMPT = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_HYSTERESIS = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_IR_PROTECT = 3'd4;
    localparam logic [CFG_AW-1:0] CFG_BLE_PROTECT = 3'd5;

    // configuration reset values
    localparam logic [MV_W-1:0]   RST_MIN_LEVEL  = 13'd2000;
    localparam logic [MV_W-1:0]   RST_MAX_LEVEL  = 13'd3000;
    localparam logic [MV_W-1:0]   RST_LOW_PROMPT = 13'd2400;
    localparam logic [HYST_W-1:0] RST_HYSTERESIS = 8'd50;
    localparam logic [MV_W-1:0]   RST_IR_PROTECT = 13'd2200;
    localparam logic [MV_W-1:0]   RST_BLE_PROTECT = 13'd2100;

    localparam int DEF_WINDOW_SAMPLES = 8;

    // thresholds used by the flag stage
    typedef struct packed {
        logic [MV_W-1:0]   low_prompt;
        logic [HYST_W-1:0] hysteresis;
        logic [MV_W-1:0]   ir_protect;
        logic [MV_W-1:0]   ble_protect;
    } t_thresh;

    // beat leaving the accumulator stage
    typedef struct packed {
        logic [MV_W-1:0]    measured;
        logic [LEVEL_W-1:0] level;
        logic               win;
        logic [SUM_W-1:0]   sum;
    } t_acc_item;

    // beat leaving the averaging stage
    typedef struct packed {
        logic [MV_W-1:0]    measured;
        logic [LEVEL_W-1:0] level;
        logic               win;
        logic [MV_W-1:0]    avg;
    } t_avg_item;

endpackage

>>> design/blm_sample.sv
// ----------------------------------------------------------------------------
// blm_sample
// Input register, running sum and window count, and per-sample level.
// ----------------------------------------------------------------------------
module blm_sample import blm_pkg::*; #(
    parameter int WINDOW_SAMPLES = DEF_WINDOW_SAMPLES
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [SAMPLE_W-1:0] i_sample,
    input  logic                i_skip,
    input  logic [MV_W-1:0]     i_min_level,
    input  logic [MV_W-1:0]     i_max_level,
    output logic                o_valid,
    input  logic                i_ready,
    output t_acc_item           o_item
);

    localparam int CNT_W = $clog2(WINDOW_SAMPLES + 1);
    localparam logic [CNT_W-1:0] WIN_LAST = CNT_W'(WINDOW_SAMPLES - 1);

    logic                r_v1;
    logic [SAMPLE_W-1:0] r_sample;
    logic                r_skip;
    logic                r_v2;
    t_acc_item           r_item;

    logic [CNT_W-1:0]   r_count;
    logic [SUM_W-1:0]   r_sum;
    logic [MV_W-1:0]    r_held_measured;
    logic [LEVEL_W-1:0] r_held_level;

    logic               w_rdy1;
    logic               w_rdy2;
    logic               w_take;
    logic [MV_W-1:0]    w_meas;
    logic [MV_W-1:0]    w_lo;
    logic [MV_W-1:0]    w_clamp;
    logic [MV_W-1:0]    w_diff;
    logic [MV_W+LVL_RECIP_W-1:0] w_prod;
    logic [LEVEL_W-1:0] w_level;
    logic [SUM_W-1:0]   w_sum;
    logic               w_win;

    // handshake
    assign w_rdy2  = !r_v2 || i_ready;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_ready = w_rdy1;
    assign w_take  = r_v1 && w_rdy2 && !r_skip;

    // measured voltage, clamp and level
    assign w_meas  = MV_W'(r_sample) + OFFSET_MV;
    assign w_lo    = (w_meas < i_min_level) ? i_min_level : w_meas;
    assign w_clamp = (w_lo > i_max_level) ? i_max_level : w_lo;
    assign w_diff  = w_clamp - i_min_level;
    assign w_prod  = w_diff * LVL_RECIP;
    assign w_level = (w_clamp < i_min_level) ? '0 : w_prod[LVL_SH +: LEVEL_W];

    // accumulate and window end
    assign w_sum = r_sum + SUM_W'(w_meas);
    assign w_win = (r_count == WIN_LAST);

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_rdy1) begin
            r_v1 <= i_valid;
        end
        if (w_rdy1) begin
            r_sample <= i_sample;
            r_skip   <= i_skip;
        end
    end

    // accumulator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count         <= '0;
            r_sum           <= '0;
            r_held_measured <= '0;
            r_held_level    <= '0;
        end else if (w_take) begin
            r_held_measured <= w_meas;
            r_held_level    <= w_level;
            if (w_win) begin
                r_count <= '0;
                r_sum   <= '0;
            end else begin
                r_count <= r_count + 1'b1;
                r_sum   <= w_sum;
            end
        end
    end

    // stage register toward the averaging stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_rdy2) begin
            r_v2 <= r_v1;
        end
        if (w_rdy2) begin
            if (r_skip) begin
                r_item.measured <= r_held_measured;
                r_item.level    <= r_held_level;
                r_item.win      <= 1'b0;
            end else begin
                r_item.measured <= w_meas;
                r_item.level    <= w_level;
                r_item.win      <= w_win;
            end
            r_item.sum <= w_sum;
        end
    end

    assign o_valid = r_v2;
    assign o_item  = r_item;

endmodule

>>> design/blm_avg.sv
// ----------------------------------------------------------------------------
// blm_avg
// Window average by multiplication with the window reciprocal.
// ----------------------------------------------------------------------------
module blm_avg import blm_pkg::*; #(
    parameter int WINDOW_SAMPLES = DEF_WINDOW_SAMPLES
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_acc_item i_item,
    output logic      o_valid,
    input  logic      i_ready,
    output t_avg_item o_item
);

    localparam longint unsigned RECIP_FULL =
        ((64'd1 << RECIP_SH) + WINDOW_SAMPLES - 1) / WINDOW_SAMPLES;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

    logic                      r_valid;
    t_avg_item                 r_item;
    logic                      w_rdy;
    logic [SUM_W+RECIP_W-1:0]  w_prod;

    assign w_rdy   = !r_valid || i_ready;
    assign o_ready = w_rdy;
    assign w_prod  = i_item.sum * RECIP;

    // average register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_rdy) begin
            r_valid <= i_valid;
        end
        if (w_rdy) begin
            r_item.measured <= i_item.measured;
            r_item.level    <= i_item.level;
            r_item.win      <= i_item.win;
            r_item.avg      <= w_prod[RECIP_SH +: MV_W];
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

>>> design/blm_flags.sv
// ----------------------------------------------------------------------------
// blm_flags
// Threshold flags with low battery hysteresis, and the output register.
// ----------------------------------------------------------------------------
module blm_flags import blm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  t_avg_item          i_item,
    input  t_thresh            i_thresh,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [MV_W-1:0]    o_measured,
    output logic [LEVEL_W-1:0] o_level,
    output logic               o_low,
    output logic               o_ir,
    output logic               o_ble
);

    logic               r_low_flag;
    logic               r_ir_flag;
    logic               r_ble_flag;
    logic               r_valid;
    logic [MV_W-1:0]    r_measured;
    logic [LEVEL_W-1:0] r_level;
    logic               r_low;
    logic               r_ir;
    logic               r_ble;

    logic               w_rdy;
    logic [MV_W:0]      w_release;
    logic               n_low_flag;
    logic               n_ir_flag;
    logic               n_ble_flag;

    assign w_rdy   = !r_valid || i_ready;
    assign o_ready = w_rdy;

    // flag update at window end
    assign w_release = {1'b0, i_thresh.low_prompt} + (MV_W+1)'(i_thresh.hysteresis);
    always_comb begin
        n_low_flag = r_low_flag;
        n_ir_flag  = r_ir_flag;
        n_ble_flag = r_ble_flag;
        if (i_item.win) begin
            if (i_item.avg <= i_thresh.low_prompt) begin
                n_low_flag = 1'b1;
            end else if ({1'b0, i_item.avg} > w_release) begin
                n_low_flag = 1'b0;
            end
            n_ir_flag  = (i_item.avg <= i_thresh.ir_protect);
            n_ble_flag = (i_item.avg <= i_thresh.ble_protect);
        end
    end

    // flag state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_flag <= 1'b0;
            r_ir_flag  <= 1'b0;
            r_ble_flag <= 1'b0;
        end else if (i_valid && w_rdy) begin
            r_low_flag <= n_low_flag;
            r_ir_flag  <= n_ir_flag;
            r_ble_flag <= n_ble_flag;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_rdy) begin
            r_valid <= i_valid;
        end
        if (w_rdy) begin
            r_measured <= i_item.measured;
            r_level    <= i_item.level;
            r_low      <= n_low_flag;
            r_ir       <= n_ir_flag;
            r_ble      <= n_ble_flag;
        end
    end

    assign o_valid    = r_valid;
    assign o_measured = r_measured;
    assign o_level    = r_level;
    assign o_low      = r_low;
    assign o_ir       = r_ir;
    assign o_ble      = r_ble;

endmodule

>>> design/battery_level_monitor.sv
// ----------------------------------------------------------------------------
// battery_level_monitor
// Battery reading monitor: per-sample level, windowed average and
// threshold flags with hysteresis on the low battery warning.
//
// Input stream: one beat per converter reading, tdata holds sample_mv and
// tuser the skip flag. A skipped beat leaves all state alone and repeats
// the last outputs. Output stream: one beat per input beat, in order, with
// measured_mv and level in tdata and the three flags in tuser.
// Path from input beat to output beat: input register, accumulator stage,
// reciprocal multiply, flag stage with output register. Throughput is one
// beat per cycle while the receiver is ready; every stage has its own valid
// bit, so bubbles close up and a new beat is taken while a result waits.
// When the receiver stalls, beats pile up in the stages and tready falls
// only once all of them are full.
// Synchronous active-low reset clears the stages, the sum, the count, the
// held values and the flags, and loads the register defaults.
// Registers are written through a plain write port with no wait.
// ----------------------------------------------------------------------------
module battery_level_monitor import blm_pkg::*; #(
    parameter int WINDOW_SAMPLES = DEF_WINDOW_SAMPLES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input stream
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic [15:0]       i_s_axis_tdata,   // [11:0] sample_mv
    input  logic              i_s_axis_tuser,   // [0] skip
    // output stream
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output logic [23:0]       o_m_axis_tdata,   // [12:0] measured_mv, [21:13] level
    output logic [2:0]        o_m_axis_tuser,   // [0] low_battery, [1] ir_protect,
                                                // [2] ble_protect
    // register write port
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_addr,
    input  logic [MV_W-1:0]   i_cfg_wdata
);

    logic [MV_W-1:0]    r_min_level;
    logic [MV_W-1:0]    r_max_level;
    t_thresh            r_thresh;

    logic               w_acc_valid;
    logic               w_acc_ready;
    t_acc_item          w_acc_item;
    logic               w_avg_valid;
    logic               w_avg_ready;
    t_avg_item          w_avg_item;
    logic [MV_W-1:0]    w_measured;
    logic [LEVEL_W-1:0] w_level;
    logic               w_low;
    logic               w_ir;
    logic               w_ble;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_level          <= RST_MIN_LEVEL;
            r_max_level          <= RST_MAX_LEVEL;
            r_thresh.low_prompt  <= RST_LOW_PROMPT;
            r_thresh.hysteresis  <= RST_HYSTERESIS;
            r_thresh.ir_protect  <= RST_IR_PROTECT;
            r_thresh.ble_protect <= RST_BLE_PROTECT;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_MIN_LEVEL:   r_min_level          <= i_cfg_wdata;
                CFG_MAX_LEVEL:   r_max_level          <= i_cfg_wdata;
                CFG_LOW_PROMPT:  r_thresh.low_prompt  <= i_cfg_wdata;
                CFG_HYSTERESIS:  r_thresh.hysteresis  <= i_cfg_wdata[HYST_W-1:0];
                CFG_IR_PROTECT:  r_thresh.ir_protect  <= i_cfg_wdata;
                CFG_BLE_PROTECT: r_thresh.ble_protect <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // accumulator and level
    blm_sample #(
        .WINDOW_SAMPLES(WINDOW_SAMPLES)
    ) u_sample (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_sample    (i_s_axis_tdata[SAMPLE_W-1:0]),
        .i_skip      (i_s_axis_tuser),
        .i_min_level (r_min_level),
        .i_max_level (r_max_level),
        .o_valid     (w_acc_valid),
        .i_ready     (w_acc_ready),
        .o_item      (w_acc_item)
    );

    // window average
    blm_avg #(
        .WINDOW_SAMPLES(WINDOW_SAMPLES)
    ) u_avg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_acc_valid),
        .o_ready (w_acc_ready),
        .i_item  (w_acc_item),
        .o_valid (w_avg_valid),
        .i_ready (w_avg_ready),
        .o_item  (w_avg_item)
    );

    // flags and output register
    blm_flags u_flags (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_avg_valid),
        .o_ready    (w_avg_ready),
        .i_item     (w_avg_item),
        .i_thresh   (r_thresh),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_measured (w_measured),
        .o_level    (w_level),
        .o_low      (w_low),
        .o_ir       (w_ir),
        .o_ble      (w_ble)
    );

    // output beat packing
    assign o_m_axis_tdata = {2'b00, w_level, w_measured};
    assign o_m_axis_tuser = {w_ble, w_ir, w_low};

endmodule
